### hdl/huffman_code_bit_packer_assert.svh
// Assertion macros shared by the encoder. Each expects clk and rst in scope.
`ifndef HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH

// Same-cycle implication.
`define HCBP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("huffman_code_bit_packer: assertion failed");

// Next-cycle implication.
`define HCBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("huffman_code_bit_packer: assertion failed");

`endif

### hdl/hcbp_pkg.sv
package hcbp_pkg;

  localparam int KIND_W = 2;
  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_END    = 2'd2
  } kind_t;

  // Control of the item sitting behind the table read.
  typedef struct packed {
    logic  valid;
    kind_t kind;
  } stage_ctrl_t;

endpackage

### hdl/hcbp_in_if.sv
interface hcbp_in_if;
  logic                             valid;
  logic                             ready;
  logic [hcbp_pkg::KIND_W-1:0]      kind;
  logic [hcbp_pkg::SYM_W-1:0]       symbol;
  logic [hcbp_pkg::CODE_W-1:0]      code_bits;
  logic [hcbp_pkg::LEN_W-1:0]       code_len;

  modport source (output valid, kind, symbol, code_bits, code_len, input ready);
  modport sink   (input valid, kind, symbol, code_bits, code_len, output ready);
endinterface

### hdl/hcbp_out_if.sv
interface hcbp_out_if;
  logic                             valid;
  logic                             ready;
  logic [hcbp_pkg::BYTE_W-1:0]      out_byte;
  logic                             byte_valid;
  logic                             run_end;
  logic                             stream_end;

  modport source (output valid, out_byte, byte_valid, run_end, stream_end, input ready);
  modport sink   (input valid, out_byte, byte_valid, run_end, stream_end, output ready);
endinterface

### hdl/hcbp_table.sv
module hcbp_table #(
  parameter int SYMBOL_COUNT  = 256,
  parameter int MAX_CODE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic [hcbp_pkg::KIND_W-1:0]       kind,
  input  logic [hcbp_pkg::SYM_W-1:0]        symbol,
  input  logic [hcbp_pkg::CODE_W-1:0]       code_bits,
  input  logic [hcbp_pkg::LEN_W-1:0]        code_len,
  input  logic                              advance,
  output hcbp_pkg::stage_ctrl_t             stage,
  output logic [MAX_CODE_BITS-1:0]          rd_code,
  output logic [$clog2(MAX_CODE_BITS+1)-1:0] rd_len
);

  localparam int IW = $clog2(SYMBOL_COUNT);
  localparam int LW = $clog2(MAX_CODE_BITS + 1);
  localparam int DW = MAX_CODE_BITS + LW;

  logic [DW-1:0]           mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] vld;
  logic [DW-1:0]           mem_q;
  logic                    hit;

  hcbp_pkg::kind_t         in_kind;
  logic                    in_range;
  logic [IW-1:0]           idx;
  logic [LW-1:0]           len_sat;
  logic [hcbp_pkg::CODE_W:0] mask_wide;
  logic [hcbp_pkg::CODE_W-1:0] code_masked;
  logic                    wr_en;

  always_comb begin
    in_kind     = hcbp_pkg::kind_t'(kind);
    in_range    = {1'b0, symbol} < (hcbp_pkg::SYM_W + 1)'(SYMBOL_COUNT);
    idx         = symbol[IW-1:0];
    len_sat     = (code_len > hcbp_pkg::LEN_W'(MAX_CODE_BITS)) ? LW'(MAX_CODE_BITS)
                                                               : code_len[LW-1:0];
    mask_wide   = ((hcbp_pkg::CODE_W + 1)'(1) << len_sat) - (hcbp_pkg::CODE_W + 1)'(1);
    code_masked = code_bits & mask_wide[hcbp_pkg::CODE_W-1:0];
    wr_en       = accept && (in_kind == hcbp_pkg::KIND_LOAD) && in_range;
  end

  // A load writes at its accept edge, so an encode accepted on the next edge
  // already reads the new entry.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx] <= {code_masked[MAX_CODE_BITS-1:0], len_sat};
    end
    if (accept) begin
      mem_q <= mem[idx];
      hit   <= in_range && vld[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
      stage.kind  <= hcbp_pkg::KIND_LOAD;
    end else if (accept) begin
      stage.valid <= (in_kind == hcbp_pkg::KIND_ENCODE) || (in_kind == hcbp_pkg::KIND_END);
      stage.kind  <= in_kind;
    end else if (advance) begin
      stage.valid <= 1'b0;
    end
  end

  assign rd_code = hit ? mem_q[DW-1:LW] : '0;
  assign rd_len  = hit ? mem_q[LW-1:0]  : '0;

endmodule

### hdl/hcbp_packer.sv
module hcbp_packer #(
  parameter int MAX_CODE_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  hcbp_pkg::stage_ctrl_t              stage,
  input  logic [MAX_CODE_BITS-1:0]           rd_code,
  input  logic [$clog2(MAX_CODE_BITS+1)-1:0] rd_len,
  output logic                               advance,
  hcbp_out_if.source                         result
);

  localparam int AW = MAX_CODE_BITS + 8;
  localparam int NB = (MAX_CODE_BITS + 7) / 8;
  localparam int EW = NB * 8;
  localparam int TW = $clog2(MAX_CODE_BITS + 8);
  localparam int SW = $clog2(AW + 1);
  localparam int CW = $clog2(NB + 1);

  // Bit accumulator, left aligned, and its fill.
  logic [7:0]    pend;
  logic [2:0]    pc;
  logic          any;

  // Byte emitter: up to NB bytes waiting, head byte in the top bits.
  logic [EW-1:0] ebuf;
  logic [CW-1:0] ecnt;
  logic          ebv;
  logic          eend;

  logic [TW-1:0] total;
  logic [SW-1:0] shamt;
  logic [AW-1:0] acc;
  logic [AW-1:0] acc_sh;
  logic [CW-1:0] nb;
  logic [7:0]    pend_new;
  logic          is_end;
  logic          produce;
  logic          pop;
  logic          emit_free;
  logic          load_emit;

  always_comb begin
    total     = TW'(pc) + TW'(rd_len);
    shamt     = SW'(AW) - SW'(total);
    acc       = {pend, {MAX_CODE_BITS{1'b0}}} | (AW'(rd_code) << shamt);
    nb        = CW'(total >> 3);
    acc_sh    = acc << {nb, 3'b000};
    pend_new  = acc_sh[AW-1 -: 8];
    is_end    = (stage.kind == hcbp_pkg::KIND_END);
    produce   = stage.valid && (is_end || (nb != '0));
    pop       = (ecnt != '0) && result.ready;
    emit_free = (ecnt == '0) || ((ecnt == CW'(1)) && result.ready);
    advance   = stage.valid && (!produce || emit_free);
    load_emit = advance && produce;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      pc   <= '0;
      any  <= 1'b0;
    end else if (advance) begin
      if (is_end) begin
        pend <= '0;
        pc   <= '0;
        any  <= 1'b0;
      end else begin
        pend <= pend_new;
        pc   <= total[2:0];
        if (nb != '0) begin
          any <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ecnt <= '0;
    end else if (load_emit) begin
      ecnt <= is_end ? CW'(1) : nb;
    end else if (pop) begin
      ecnt <= ecnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_emit) begin
      if (is_end) begin
        // Pending bits are zero below the fill, so an empty accumulator gives 0.
        ebuf <= EW'(pend) << (EW - 8);
        ebv  <= (pc != '0) || !any;
        eend <= 1'b1;
      end else begin
        ebuf <= acc[AW-1 -: EW];
        ebv  <= 1'b1;
        eend <= 1'b0;
      end
    end else if (pop) begin
      ebuf <= ebuf << 8;
    end
  end

  assign result.valid      = (ecnt != '0);
  assign result.out_byte   = ebuf[EW-1 -: 8];
  assign result.byte_valid = ebv;
  assign result.run_end    = (ecnt == CW'(1));
  assign result.stream_end = eend;

endmodule

### hdl/huffman_code_bit_packer.sv
// An accepted item is registered into stage two, then into the emitter that drives its beats.
// Throughput: one item per cycle; an encode that completes n bytes holds the output n beats.
// Output backpressure stalls input only when the packer must emit while bytes still wait.
// Reset (rst, synchronous) clears all SYMBOL_COUNT table valid bits together, plus the
// accumulator and emitter; there is no clearing pass and a beat may be taken right after.
`include "huffman_code_bit_packer_assert.svh"

module huffman_code_bit_packer #(
  parameter int SYMBOL_COUNT  = 256,
  parameter int MAX_CODE_BITS = 32
) (
  input logic        clk,
  input logic        rst,
  hcbp_in_if.sink    item,
  hcbp_out_if.source result
);

  // The design is a two-stage pipeline around one synchronous table memory.
  // Stage one: an accepted beat either writes the table (loads) or issues a
  // read of the symbol's entry (encodes and flushes). Writes land at the
  // accept edge, so a following encode on the very next edge sees them with
  // no forwarding. A per-entry valid bit makes never-written entries read as
  // absent, which stands in for clearing the memory at reset.
  //
  // Stage two: the packer merges the looked-up code into the pending bits,
  // forms every completed byte at once and hands them to a small emitter
  // that drives the output one byte per beat. Items that complete no byte
  // just update the accumulator and pass even while the emitter is busy.

  localparam int LW = $clog2(MAX_CODE_BITS + 1);

  hcbp_pkg::stage_ctrl_t    stage;
  logic [MAX_CODE_BITS-1:0] rd_code;
  logic [LW-1:0]            rd_len;
  logic                     advance;
  logic                     accept;

  // The second stage frees itself in the same cycle it finishes, so the
  // input can keep streaming one beat per cycle unless the emitter stalls
  // stage two. Nothing is taken while reset is held.
  assign item.ready = !rst && (!stage.valid || advance);
  assign accept     = item.valid && item.ready;

  hcbp_table #(
    .SYMBOL_COUNT  (SYMBOL_COUNT),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .kind      (item.kind),
    .symbol    (item.symbol),
    .code_bits (item.code_bits),
    .code_len  (item.code_len),
    .advance   (advance),
    .stage     (stage),
    .rd_code   (rd_code),
    .rd_len    (rd_len)
  );

  hcbp_packer #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_packer (
    .clk     (clk),
    .rst     (rst),
    .stage   (stage),
    .rd_code (rd_code),
    .rd_len  (rd_len),
    .advance (advance),
    .result  (result)
  );

  // Input only stalls behind an occupied second stage.
  `HCBP_ASSERT_NOW(a_ready_stall, !item.ready, stage.valid)
  // A flush result is always the last of its run.
  `HCBP_ASSERT_NOW(a_end_is_last, result.valid && result.stream_end, result.run_end)
  // Only a flush marker may carry no byte.
  `HCBP_ASSERT_NOW(a_marker_only_end, result.valid && !result.byte_valid, result.stream_end)
  // A flush that leaves stage two shows up as a stream end beat next cycle.
  `HCBP_ASSERT_NEXT(a_flush_emits, advance && stage.kind == hcbp_pkg::KIND_END,
                    result.valid && result.stream_end)

endmodule
